FILE: rtl/gfpa_pkg.sv
package gfpa_pkg;

  localparam int P_W       = 16;
  localparam int DEG_W     = 5;
  localparam int RANK_W    = 31;
  localparam int RECIP_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 6;

  // reciprocal floor(2^32 / p), one quotient bit a step
  localparam int RECIP_STEPS = RECIP_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_PRIME       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_ORDER = 2'd2;

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_NEG = 1'b1;

  localparam logic [P_W-1:0] P_MIN = 16'd2;

  typedef struct packed {
    logic [P_W-1:0]     p;
    logic [RECIP_W-1:0] m;
    logic [DEG_W-1:0]   e;
  } gfpa_cfg_t;

  typedef struct packed {
    logic              vld;
    logic              neg;
    logic              err;
    logic [RANK_W-1:0] a;
    logic [RANK_W-1:0] b;
    logic [RANK_W-1:0] rank;
    logic [P_W-1:0]    d;
  } gfpa_item_t;

endpackage

FILE: rtl/gfpa_cfg.sv
module gfpa_cfg #(
  parameter int MAX_DEGREE = 31
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_valid,
  input  logic [gfpa_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [gfpa_pkg::RANK_W-1:0]               cfg_data,
  output gfpa_pkg::gfpa_cfg_t                       cfg,
  output logic [gfpa_pkg::RANK_W-1:0]               fo,
  output logic [MAX_DEGREE-1:0][gfpa_pkg::RANK_W-1:0] pow,
  output logic                                      busy
);
  import gfpa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } gfpa_state_t;

  localparam logic [48:0] TWO32 = 49'h1_0000_0000;

  gfpa_state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [P_W-1:0]                   p_r, p_nxt;
  logic [DEG_W-1:0]                 e_r, e_nxt;
  logic [RANK_W-1:0]                fo_r, fo_nxt;
  logic [P_W-1:0]                   rem_r, rem_nxt;
  logic [RECIP_W-1:0]               m_r, m_nxt;
  logic [RANK_W-1:0]                run_pow_r, run_pow_nxt;
  logic [MAX_DEGREE-1:0][RANK_W-1:0] pow_r, pow_nxt;

  logic             wr_prime;
  logic             calc_last;
  logic [P_W:0]     trial;
  logic             trial_ge;
  logic [46:0]      pow_prod;
  logic [P_W-1:0]   p_wr;
  logic [DEG_W-1:0] deg_wr;

  assign wr_prime  = cfg_valid && (cfg_index == REG_PRIME);
  assign calc_last = (state_r == ST_CALC) && (cnt_r == CNT_W'(RECIP_STEPS - 1));
  assign trial     = {rem_r, (cnt_r == '0)};
  assign trial_ge  = trial >= {1'b0, p_r};
  assign pow_prod  = 47'(run_pow_r) * 47'(p_r);
  assign p_wr      = (cfg_data[P_W-1:0] < P_MIN) ? P_MIN : cfg_data[P_W-1:0];
  assign deg_wr    = (cfg_data[DEG_W-1:0] > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE)
                                                                 : cfg_data[DEG_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    p_nxt       = p_r;
    e_nxt       = e_r;
    fo_nxt      = fo_r;
    rem_nxt     = rem_r;
    m_nxt       = m_r;
    run_pow_nxt = run_pow_r;
    pow_nxt     = pow_r;
    if (state_r == ST_CALC) begin
      rem_nxt     = trial_ge ? P_W'(trial - {1'b0, p_r}) : trial[P_W-1:0];
      m_nxt       = {m_r[RECIP_W-2:0], trial_ge};
      run_pow_nxt = pow_prod[RANK_W-1:0];
      cnt_nxt     = cnt_r + 1'b1;
      for (int k = 0; k < MAX_DEGREE; k++) begin
        if (cnt_r == CNT_W'(k)) begin
          pow_nxt[k] = run_pow_r;
        end
      end
      if (calc_last) begin
        state_nxt = ST_IDLE;
      end
    end
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRIME: begin
          p_nxt       = p_wr;
          state_nxt   = ST_CALC;
          cnt_nxt     = '0;
          rem_nxt     = '0;
          m_nxt       = '0;
          run_pow_nxt = RANK_W'(1);
        end
        REG_DEGREE:      e_nxt  = deg_wr;
        REG_FIELD_ORDER: fo_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CALC;
      cnt_r     <= '0;
      p_r       <= P_MIN;
      e_r       <= DEG_W'(1);
      fo_r      <= RANK_W'(2);
      rem_r     <= '0;
      m_r       <= '0;
      run_pow_r <= RANK_W'(1);
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      p_r       <= p_nxt;
      e_r       <= e_nxt;
      fo_r      <= fo_nxt;
      rem_r     <= rem_nxt;
      m_r       <= m_nxt;
      run_pow_r <= run_pow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pow_r <= pow_nxt;
  end

  assign cfg.p = p_r;
  assign cfg.m = m_r;
  assign cfg.e = e_r;
  assign fo    = fo_r;
  assign pow   = pow_r;
  assign busy  = (state_r == ST_CALC);

`ifndef ASSERT_OFF
  // finished reciprocal is floor(2^32 / p)
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(calc_last && !wr_prime) |->
      (49'(m_r) * 49'(p_r) <= TWO32) &&
      (TWO32 - 49'(m_r) * 49'(p_r) < 49'(p_r)))
    else $error("reciprocal wrong after calculation");
`endif

endmodule

FILE: rtl/gfpa_digit.sv
module gfpa_digit #(
  parameter int DIG = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  gfpa_pkg::gfpa_cfg_t           cfg,
  input  logic [gfpa_pkg::RANK_W-1:0]   pow_prev,
  input  gfpa_pkg::gfpa_item_t          item_i,
  output gfpa_pkg::gfpa_item_t          item_o
);
  import gfpa_pkg::*;

  localparam logic [DEG_W-1:0] DIG_V = DEG_W'(DIG);

  // stage 1: quotient estimates and weight of the previous digit
  logic              vld1_r, neg1_r, err1_r;
  logic [RANK_W-1:0] a1_r, b1_r, rank1_r, term1_r, qa1_r, qb1_r;
  logic [62:0]       qa_prod, qb_prod;
  logic [46:0]       term_prod;

  // stage 2: quotient times base, rank update
  logic              vld2_r, neg2_r, err2_r;
  logic [RANK_W-1:0] a2_r, b2_r, rank2_r, qa2_r, qb2_r, qpa2_r, qpb2_r;
  logic [RANK_W-1:0] rank2_nxt;
  logic [46:0]       qpa_prod, qpb_prod;

  // stage 3: remainder correction and digit combine
  gfpa_item_t        item_r, item_nxt;
  logic [RANK_W-1:0] ra, rb, p_ext;
  logic              ra_ge, rb_ge;
  logic [P_W-1:0]    da, db, d_neg, d_add;
  logic [P_W:0]      d_sum;
  logic              dig_used;

  assign qa_prod   = 63'(item_i.a) * 63'(cfg.m);
  assign qb_prod   = 63'(item_i.b) * 63'(cfg.m);
  assign term_prod = 47'(item_i.d) * 47'(pow_prev);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= item_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg1_r  <= item_i.neg;
      err1_r  <= item_i.err;
      a1_r    <= item_i.a;
      b1_r    <= item_i.b;
      rank1_r <= item_i.rank;
      term1_r <= term_prod[RANK_W-1:0];
      qa1_r   <= qa_prod[62:RECIP_W];
      qb1_r   <= qb_prod[62:RECIP_W];
    end
  end

  assign qpa_prod  = 47'(qa1_r) * 47'(cfg.p);
  assign qpb_prod  = 47'(qb1_r) * 47'(cfg.p);
  assign rank2_nxt = rank1_r + term1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg2_r  <= neg1_r;
      err2_r  <= err1_r;
      a2_r    <= a1_r;
      b2_r    <= b1_r;
      rank2_r <= rank2_nxt;
      qa2_r   <= qa1_r;
      qb2_r   <= qb1_r;
      qpa2_r  <= qpa_prod[RANK_W-1:0];
      qpb2_r  <= qpb_prod[RANK_W-1:0];
    end
  end

  assign p_ext    = RANK_W'(cfg.p);
  assign ra       = a2_r - qpa2_r;
  assign rb       = b2_r - qpb2_r;
  assign ra_ge    = ra >= p_ext;
  assign rb_ge    = rb >= p_ext;
  assign da       = ra_ge ? P_W'(ra - p_ext) : ra[P_W-1:0];
  assign db       = rb_ge ? P_W'(rb - p_ext) : rb[P_W-1:0];
  assign d_sum    = (P_W+1)'(da) + (P_W+1)'(db);
  assign d_add    = (d_sum >= (P_W+1)'(cfg.p)) ? P_W'(d_sum - (P_W+1)'(cfg.p))
                                               : d_sum[P_W-1:0];
  assign d_neg    = (da == '0) ? '0 : cfg.p - da;
  assign dig_used = DIG_V < cfg.e;

  always_comb begin
    item_nxt.vld  = vld2_r;
    item_nxt.neg  = neg2_r;
    item_nxt.err  = err2_r;
    item_nxt.a    = qa2_r + RANK_W'(ra_ge);
    item_nxt.b    = qb2_r + RANK_W'(rb_ge);
    item_nxt.rank = rank2_r;
    if (!dig_used) begin
      item_nxt.d = '0;
    end else if (neg2_r == KIND_NEG) begin
      item_nxt.d = d_neg;
    end else begin
      item_nxt.d = d_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (adv) begin
      item_r.vld <= item_nxt.vld;
    end
    if (adv) begin
      item_r.neg  <= item_nxt.neg;
      item_r.err  <= item_nxt.err;
      item_r.a    <= item_nxt.a;
      item_r.b    <= item_nxt.b;
      item_r.rank <= item_nxt.rank;
      item_r.d    <= item_nxt.d;
    end
  end

  assign item_o = item_r;

endmodule

FILE: rtl/gfpa_out.sv
module gfpa_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gfpa_pkg::RANK_W-1:0]   pow_last,
  input  gfpa_pkg::gfpa_item_t          item_i,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [gfpa_pkg::RANK_W-1:0]   out_sum_rank,
  output logic                          out_range_error,
  output logic                          adv
);
  import gfpa_pkg::*;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              err;
  } gfpa_res_t;

  logic              vldf_r, errf_r;
  logic [RANK_W-1:0] rankf_r, termf_r;
  logic [46:0]       term_prod;

  gfpa_res_t   slot0_r, slot0_nxt, slot1_r, slot1_nxt, res_new;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign term_prod = 47'(item_i.d) * 47'(pow_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldf_r <= 1'b0;
    end else if (adv) begin
      vldf_r <= item_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      errf_r  <= item_i.err;
      rankf_r <= item_i.rank;
      termf_r <= term_prod[RANK_W-1:0];
    end
  end

  assign out_valid    = (cnt_r != 2'd0);
  assign adv          = (cnt_r != 2'd2) || !out_stall;
  assign push         = adv && vldf_r;
  assign pop          = out_valid && !out_stall;
  assign res_new.rank = errf_r ? '0 : rankf_r + termf_r;
  assign res_new.err  = errf_r;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          slot0_nxt = res_new;
        end else begin
          slot1_nxt = res_new;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        cnt_nxt   = cnt_r - 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          slot0_nxt = res_new;
        end else begin
          slot0_nxt = slot1_r;
          slot1_nxt = res_new;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_sum_rank    = slot0_r.rank;
  assign out_range_error = slot0_r.err;

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != 2'd2) || pop)
    else $error("beat pushed into full output queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("output queue count lost a beat");

  assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("output queue count repeated a beat");
`endif

endmodule

FILE: rtl/gf_pe_add_negate.sv
// Adds or negates elements of GF(p^e) given by their base-p rank. Each of the MAX_DEGREE
// digit positions is a three-stage slice (reciprocal multiply, quotient times p, remainder
// correction and digit combine), so one item is taken per cycle while in_stall is low; a
// two-beat output queue keeps the input open while a result waits. The config port never
// stalls. After reset and after every write of the prime the block computes floor(2^32/p)
// and the powers of p, one step a cycle, and holds in_stall high until that is done;
// degree and field order take effect at once.
module gf_pe_add_negate #(
  parameter int MAX_DEGREE = 31
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic [gfpa_pkg::RANK_W-1:0]        in_operand_a,
  input  logic [gfpa_pkg::RANK_W-1:0]        in_operand_b,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gfpa_pkg::RANK_W-1:0]        out_sum_rank,
  output logic                               out_range_error,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gfpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gfpa_pkg::RANK_W-1:0]        cfg_data
);
  import gfpa_pkg::*;

  gfpa_cfg_t                         cfg;
  logic [RANK_W-1:0]                 fo;
  logic [MAX_DEGREE-1:0][RANK_W-1:0] pow;
  logic                              busy;
  logic                              adv;
  logic                              in_acc;
  logic                              err_nxt;
  gfpa_item_t                        chain [0:MAX_DEGREE];
  gfpa_item_t                        in_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy || !adv;
  assign in_acc    = in_valid && !in_stall;
  assign err_nxt   = (in_operand_a >= fo) || ((in_kind == KIND_ADD) && (in_operand_b >= fo));

  gfpa_cfg #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .fo        (fo),
    .pow       (pow),
    .busy      (busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_r.vld <= 1'b0;
    end else if (adv) begin
      in_r.vld <= in_acc;
    end
    if (in_acc) begin
      in_r.neg  <= in_kind;
      in_r.err  <= err_nxt;
      in_r.a    <= in_operand_a;
      in_r.b    <= (in_kind == KIND_NEG) ? '0 : in_operand_b;
      in_r.rank <= '0;
      in_r.d    <= '0;
    end
  end

  assign chain[0] = in_r;

  for (genvar l = 0; l < MAX_DEGREE; l++) begin : g_dig
    localparam int PI = (l == 0) ? 0 : l - 1;
    gfpa_digit #(
      .DIG (l)
    ) u_digit (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cfg      (cfg),
      .pow_prev (pow[PI]),
      .item_i   (chain[l]),
      .item_o   (chain[l+1])
    );
  end

  gfpa_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .pow_last        (pow[MAX_DEGREE-1]),
    .item_i          (chain[MAX_DEGREE]),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_sum_rank    (out_sum_rank),
    .out_range_error (out_range_error),
    .adv             (adv)
  );

endmodule

FILE: tb/gf_pe_add_negate_tb.sv
module gf_pe_add_negate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gfpa_pkg::*;

  localparam int MAX_DEG = 31;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT = 36;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  typedef struct {
    logic              kind;
    logic [RANK_W-1:0] a;
    logic [RANK_W-1:0] b;
  } op_beat_t;

  typedef struct {
    logic [RANK_W-1:0] rank;
    logic              err;
  } sum_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_kind = KIND_ADD;
  logic [RANK_W-1:0] in_operand_a = '0;
  logic [RANK_W-1:0] in_operand_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [RANK_W-1:0] out_sum_rank;
  logic              out_range_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PRIME;
  logic [RANK_W-1:0]    cfg_data = '0;

  // field setting as the block should hold it
  logic [P_W-1:0]    char_p = 16'd2;
  logic [DEG_W-1:0]  ext_deg = 5'd1;
  logic [RANK_W-1:0] order_q = 31'd2;

  op_beat_t  pending_ops[$];
  sum_beat_t sums_due[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  logic      calm = 1'b0;

  gf_pe_add_negate #(.MAX_DEGREE(MAX_DEG)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sum_rank(out_sum_rank), .out_range_error(out_range_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic sum_beat_t gf_sum_of(logic kind, logic [RANK_W-1:0] a_in,
                                          logic [RANK_W-1:0] b_in);
    sum_beat_t res;
    longint unsigned base, place, acc, a, b, da, db, dig;
    int unsigned digits;
    logic neg;
    neg = (kind == KIND_NEG);
    a = 64'(a_in);
    b = neg ? 64'(0) : 64'(b_in);
    res.err = (a >= 64'(order_q)) || (!neg && b >= 64'(order_q));
    res.rank = '0;
    if (!res.err) begin
      base = (char_p < P_MIN) ? 64'(P_MIN) : 64'(char_p);
      digits = (ext_deg > DEG_W'(MAX_DEG)) ? 32'(MAX_DEG) : 32'(ext_deg);
      place = 1;
      acc = 0;
      for (int l = 0; l < digits; l++) begin
        if (a == 0 && b == 0) break;
        da = a % base;
        db = b % base;
        a = a / base;
        b = b / base;
        if (neg) dig = (da == 0) ? 0 : base - da;
        else dig = (da + db) % base;
        acc += dig * place;
        place *= base;
      end
      res.rank = acc[RANK_W-1:0];
    end
    return res;
  endfunction

  task automatic queue_op(logic kind, logic [RANK_W-1:0] a, logic [RANK_W-1:0] b);
    op_beat_t op;
    op.kind = kind;
    op.a = a;
    op.b = b;
    pending_ops.push_back(op);
  endtask

  // only called with the block idle
  task automatic set_field(logic [P_W-1:0] p, logic [DEG_W-1:0] e, logic [RANK_W-1:0] q);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [RANK_W-1:0]    val[3];
    idx[0] = REG_PRIME;       val[0] = RANK_W'(p);
    idx[1] = REG_DEGREE;      val[1] = RANK_W'(e);
    idx[2] = REG_FIELD_ORDER; val[2] = q;
    @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_PRIME: char_p = val[i][P_W-1:0];
        REG_DEGREE: ext_deg = val[i][DEG_W-1:0];
        default: order_q = val[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || sums_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [RANK_W-1:0] pick_operand();
    int unsigned r;
    logic [RANK_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 80 && order_q != 0) v = RANK_W'($urandom_range(0, 32'(order_q - 1)));
    else if (r < 90) begin
      case ($urandom_range(0, 3))
        0: v = '0;
        1: v = order_q - 1;
        2: v = order_q;
        default: v = RANK_MAX;
      endcase
    end else v = RANK_W'($urandom);
    return v;
  endfunction

  // stimulus and field programming
  initial begin
    static int unsigned primes[10] = '{2, 3, 5, 7, 11, 13, 31, 251, 257, 65521};
    longint unsigned pw;
    int unsigned emax;
    logic [P_W-1:0] p;
    logic [DEG_W-1:0] e;
    logic [RANK_W-1:0] q;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset setting: GF(2)
    @(negedge clk);
    queue_op(KIND_ADD, 31'd1, 31'd1);
    queue_op(KIND_NEG, 31'd1, RANK_MAX);
    queue_op(KIND_ADD, 31'd0, 31'd1);
    queue_op(KIND_ADD, 31'd2, 31'd0);
    queue_op(KIND_ADD, 31'd1, RANK_MAX);
    wait_drained();

    set_field(16'd3, 5'd4, 31'd81);
    @(negedge clk);
    queue_op(KIND_ADD, 31'd80, 31'd80);
    queue_op(KIND_NEG, 31'd80, 31'd0);
    queue_op(KIND_NEG, 31'd0, 31'd5);
    queue_op(KIND_ADD, 31'd81, 31'd0);
    queue_op(KIND_ADD, 31'd0, 31'd81);
    wait_drained();

    set_field(16'd2, 5'd31, RANK_MAX);
    @(negedge clk);
    queue_op(KIND_ADD, RANK_MAX - 1, 31'h5555_5555);
    queue_op(KIND_NEG, RANK_MAX - 1, 31'd0);
    queue_op(KIND_ADD, RANK_MAX, 31'd0);
    wait_drained();

    set_field(16'd65521, 5'd1, 31'd65521);
    @(negedge clk);
    queue_op(KIND_ADD, 31'd65520, 31'd65520);
    queue_op(KIND_NEG, 31'd1, 31'd0);
    wait_drained();

    // zero order, zero prime, zero degree
    set_field(16'd0, 5'd0, 31'd0);
    @(negedge clk);
    queue_op(KIND_ADD, 31'd0, 31'd0);
    queue_op(KIND_NEG, 31'd0, 31'd0);
    wait_drained();

    set_field(16'd1, 5'd0, 31'd100);
    @(negedge clk);
    queue_op(KIND_ADD, 31'd5, 31'd7);
    queue_op(KIND_NEG, 31'd9, 31'd0);
    wait_drained();

    // order not a power of the prime
    set_field(16'd1, 5'd3, 31'd1000);
    @(negedge clk);
    queue_op(KIND_ADD, 31'd999, 31'd3);
    queue_op(KIND_NEG, 31'd1023, 31'd0);
    wait_drained();

    set_field(16'hFFFF, 5'd31, RANK_MAX);
    @(negedge clk);
    queue_op(KIND_ADD, RANK_MAX - 1, RANK_MAX - 1);
    queue_op(KIND_NEG, RANK_MAX - 1, 31'd0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 4 == 3) begin
        p = P_W'($urandom);
        e = DEG_W'($urandom);
        q = ($urandom_range(0, 1) != 0) ? RANK_W'($urandom) : RANK_W'($urandom_range(0, 5000));
      end else begin
        p = P_W'(primes[$urandom_range(0, 9)]);
        pw = 1;
        emax = 0;
        while (emax < MAX_DEG && pw * p <= RANK_MAX) begin
          pw = pw * p;
          emax++;
        end
        e = DEG_W'($urandom_range(1, emax));
        pw = 1;
        for (int i = 0; i < e; i++) pw = pw * p;
        q = pw[RANK_W-1:0];
      end
      set_field(p, e, q);
      calm = (ph == 2);
      @(negedge clk);
      for (int n = 0; n < 90; n++)
        queue_op(($urandom_range(0, 1) != 0) ? KIND_NEG : KIND_ADD, pick_operand(),
                 pick_operand());
      wait_drained();
    end
    calm = 1'b0;

    repeat (120) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // input driver
  always @(posedge clk) begin
    op_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sums_due.push_back(gf_sum_of(in_kind, in_operand_a, in_operand_b));
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_kind <= nxt.kind;
          in_operand_a <= nxt.a;
          in_operand_b <= nxt.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    sum_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          $error("result beat with nothing outstanding: sum_rank %0d range_error %0b",
                 out_sum_rank, out_range_error);
          mismatches++;
        end else begin
          want = sums_due.pop_front();
          if (out_sum_rank !== want.rank) begin
            $error("sum_rank: expected %0d, got %0d", want.rank, out_sum_rank);
            mismatches++;
          end
          if (out_range_error !== want.err) begin
            $error("range_error: expected %0b, got %0b", want.err, out_range_error);
            mismatches++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
